@@ design/page_table_lru_fifo_defines.svh @@
// ----------------------------------------------------------------------------
// Page table assertion macros
// Concurrent assertion forms for the page table checker.
// ----------------------------------------------------------------------------
`ifndef PAGE_TABLE_LRU_FIFO_DEFINES_SVH
`define PAGE_TABLE_LRU_FIFO_DEFINES_SVH

// same-cycle implication, reset aware
`define PTLF_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, reset aware
`define PTLF_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/ptlf_pkg.sv @@
// ----------------------------------------------------------------------------
// Page table package
// Types, register indexes and defaults shared by the page table modules.
// ----------------------------------------------------------------------------
package ptlf_pkg;

	localparam int PTLF_MAX_FRAMES     = 16;
	localparam int PTLF_MAX_PAGE_SHIFT = 16;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 5;

	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PAGE_SHIFT   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_REPLACE_MODE = 2'd2;

	localparam logic [4:0] FRAME_COUNT_RST = 5'd16;
	localparam logic [4:0] PAGE_SHIFT_RST  = 5'd12;

	localparam logic MODE_LRU  = 1'b0;
	localparam logic MODE_FIFO = 1'b1;

	typedef struct packed {
		logic [31:0] virtual_address;
	} ptlf_req_t;

	typedef struct packed {
		logic        page_fault;
		logic [19:0] physical_address;
		logic [3:0]  frame_number;
	} ptlf_rsp_t;

	typedef struct packed {
		logic clear;
		logic rotate;
		logic append;
	} ptlf_tbl_op_t;

endpackage

@@ design/ptlf_stream_if.sv @@
// ----------------------------------------------------------------------------
// Page table stream channel
// Valid/ready channel carrying one payload per transfer.
// ----------------------------------------------------------------------------
interface ptlf_stream_if #(
	parameter type data_t = logic
);
	logic  valid;
	logic  ready;
	data_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

@@ design/ptlf_table.sv @@
// ----------------------------------------------------------------------------
// Page table storage
// Ordered page/frame entries, oldest first, with fill count, append and
// rotate-to-newest.
// ----------------------------------------------------------------------------
module ptlf_table import ptlf_pkg::*; #(
	parameter int MAX_FRAMES = PTLF_MAX_FRAMES,
	localparam int AW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1,
	localparam int CW = $clog2(MAX_FRAMES + 1)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ptlf_tbl_op_t         op,
	input  logic [AW-1:0]        pos,
	input  logic [CW-1:0]        used,
	input  logic [31:0]          wr_page,
	input  logic [AW-1:0]        wr_frame,
	input  logic [AW-1:0]        rd_idx,
	output logic [31:0]          rd_page,
	output logic [AW-1:0]        rd_frame,
	output logic [AW-1:0]        head_frame,
	output logic [CW-1:0]        fill
);
	logic [31:0]   page_q [MAX_FRAMES];
	logic [AW-1:0] frame_q [MAX_FRAMES];
	logic [31:0]   nxt_page [MAX_FRAMES];
	logic [AW-1:0] nxt_frame [MAX_FRAMES];
	logic [CW-1:0] fill_q;

	for (genvar g = 0; g < MAX_FRAMES; g++) begin : g_next
		if (g < MAX_FRAMES - 1) begin : g_mid
			assign nxt_page[g]  = page_q[g+1];
			assign nxt_frame[g] = frame_q[g+1];
		end else begin : g_last
			assign nxt_page[g]  = page_q[g];
			assign nxt_frame[g] = frame_q[g];
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_FRAMES; i++) begin
			if (op.rotate) begin
				if (i + 1 == 32'(used)) begin
					page_q[i]  <= wr_page;
					frame_q[i] <= wr_frame;
				end else if (i >= 32'(pos) && i + 1 < 32'(used)) begin
					page_q[i]  <= nxt_page[i];
					frame_q[i] <= nxt_frame[i];
				end
			end else if (op.append && i == 32'(used)) begin
				page_q[i]  <= wr_page;
				frame_q[i] <= wr_frame;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (op.clear) begin
			fill_q <= '0;
		end else if (op.append) begin
			fill_q <= used + CW'(1);
		end
	end

	assign rd_page    = page_q[rd_idx];
	assign rd_frame   = frame_q[rd_idx];
	assign head_frame = frame_q[0];
	assign fill       = fill_q;

endmodule

@@ design/ptlf_seq.sv @@
// ----------------------------------------------------------------------------
// Page table sequencer
// Splits the address, scans the table with one shared comparator and
// issues the table update and the result.
// ----------------------------------------------------------------------------
module ptlf_seq import ptlf_pkg::*; #(
	parameter int MAX_FRAMES     = PTLF_MAX_FRAMES,
	parameter int MAX_PAGE_SHIFT = PTLF_MAX_PAGE_SHIFT,
	localparam int AW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1,
	localparam int CW = $clog2(MAX_FRAMES + 1),
	localparam int SW = (MAX_PAGE_SHIFT > 0) ? $clog2(MAX_PAGE_SHIFT + 1) : 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	ptlf_stream_if.sink          req,
	output logic                 res_valid,
	input  logic                 res_ready,
	output ptlf_rsp_t            res,
	input  logic [CW-1:0]        frames,
	input  logic [SW-1:0]        shift,
	input  logic                 mode,
	input  logic [CW-1:0]        fill,
	output ptlf_tbl_op_t         op,
	output logic [AW-1:0]        pos,
	output logic [CW-1:0]        used,
	output logic [31:0]          wr_page,
	output logic [AW-1:0]        wr_frame,
	output logic [AW-1:0]        rd_idx,
	input  logic [31:0]          rd_page,
	input  logic [AW-1:0]        rd_frame,
	input  logic [AW-1:0]        head_frame
);
	localparam int OW = (MAX_PAGE_SHIFT > 0) ? MAX_PAGE_SHIFT : 1;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_SCAN = 4'b0010,
		S_UPD  = 4'b0100,
		S_DONE = 4'b1000
	} ptlf_state_t;

	ptlf_state_t   state_q;
	logic [CW-1:0] idx_q;
	logic [CW-1:0] used_q;
	logic [31:0]   vpage_q;
	logic [OW-1:0] offset_q;
	logic          hit_q;
	logic [AW-1:0] pos_q;
	logic [AW-1:0] frame_q;

	logic          accept;
	logic          scan_end;
	logic          scan_hit;
	logic [31:0]   off_mask;
	logic [31:0]   off_full;
	logic [31:0]   pa_wide;
	logic [31:0]   frame_ext;

	assign accept   = req.valid && req.ready;
	assign req.ready = (state_q == S_IDLE);
	assign scan_end = (idx_q == used_q);
	assign scan_hit = !scan_end && (rd_page == vpage_q);
	assign rd_idx   = idx_q[AW-1:0];
	assign off_mask = (32'd1 << shift) - 32'd1;
	assign off_full = req.payload.virtual_address & off_mask;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: if (accept) state_q <= S_SCAN;
				S_SCAN: if (scan_end || scan_hit) state_q <= S_UPD;
				S_UPD:  state_q <= S_DONE;
				S_DONE: if (res_ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				vpage_q  <= req.payload.virtual_address >> shift;
				offset_q <= off_full[OW-1:0];
				idx_q    <= '0;
				used_q   <= (fill > frames) ? frames : fill;
				hit_q    <= 1'b0;
			end
			S_SCAN: begin
				if (scan_hit) begin
					hit_q   <= 1'b1;
					pos_q   <= idx_q[AW-1:0];
					frame_q <= rd_frame;
				end else if (!scan_end) begin
					idx_q <= idx_q + CW'(1);
				end
			end
			S_UPD: begin
				if (!hit_q) begin
					frame_q <= (used_q < frames) ? used_q[AW-1:0] : head_frame;
				end
			end
			default: ;
		endcase
	end

	// table update for the scanned item
	always_comb begin
		op       = '0;
		pos      = '0;
		used     = used_q;
		wr_page  = vpage_q;
		wr_frame = frame_q;
		if (state_q == S_UPD) begin
			if (hit_q) begin
				op.rotate = (mode == MODE_LRU);
				pos       = pos_q;
			end else if (used_q < frames) begin
				op.append = 1'b1;
				wr_frame  = used_q[AW-1:0];
			end else begin
				op.rotate = 1'b1;
				wr_frame  = head_frame;
			end
		end
	end

	assign frame_ext = 32'(frame_q);
	assign pa_wide   = (frame_ext << shift) | 32'(offset_q);

	assign res_valid            = (state_q == S_DONE);
	assign res.page_fault       = !hit_q;
	assign res.physical_address = hit_q ? pa_wide[19:0] : '0;
	assign res.frame_number     = frame_ext[3:0];

endmodule

@@ design/page_table_lru_fifo.sv @@
// ----------------------------------------------------------------------------
// Page table with LRU or FIFO replacement
// Fully associative virtual-to-physical page translation.
// ----------------------------------------------------------------------------
// Each transfer on req carries one virtual word address; one result leaves on
// rsp per address. The table is scanned one entry per cycle by a single
// comparator, so an item occupies the block through the accept, scan, update
// and done states, scanning each entry up to the match (every valid entry on
// a miss). req is not ready while an item is in flight; a finished result
// waits in the output register while the next item is taken.
// Writing frame_count or page_shift empties the table; write configuration
// only while the block is idle.
// ----------------------------------------------------------------------------
module page_table_lru_fifo import ptlf_pkg::*; #(
	parameter int MAX_FRAMES     = PTLF_MAX_FRAMES,
	parameter int MAX_PAGE_SHIFT = PTLF_MAX_PAGE_SHIFT
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	ptlf_stream_if.sink           req,
	ptlf_stream_if.source         rsp
);
	localparam int AW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
	localparam int CW = $clog2(MAX_FRAMES + 1);
	localparam int SW = (MAX_PAGE_SHIFT > 0) ? $clog2(MAX_PAGE_SHIFT + 1) : 1;

	logic [4:0]    frame_count_q;
	logic [4:0]    page_shift_q;
	logic          replace_mode_q;
	logic          cfg_clear;

	logic [CW-1:0] eff_frames;
	logic [SW-1:0] eff_shift;

	logic          res_valid;
	logic          res_ready;
	ptlf_rsp_t     res;
	logic          rsp_valid_q;
	ptlf_rsp_t     rsp_q;

	ptlf_tbl_op_t  seq_op;
	ptlf_tbl_op_t  tbl_op;
	logic [AW-1:0] pos;
	logic [CW-1:0] used;
	logic [31:0]   wr_page;
	logic [AW-1:0] wr_frame;
	logic [AW-1:0] rd_idx;
	logic [31:0]   rd_page;
	logic [AW-1:0] rd_frame;
	logic [AW-1:0] head_frame;
	logic [CW-1:0] fill;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_count_q  <= FRAME_COUNT_RST;
			page_shift_q   <= PAGE_SHIFT_RST;
			replace_mode_q <= MODE_LRU;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_FRAME_COUNT:  frame_count_q  <= cfg_wdata;
				CFG_PAGE_SHIFT:   page_shift_q   <= cfg_wdata;
				CFG_REPLACE_MODE: replace_mode_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	assign cfg_clear = cfg_we && (cfg_idx inside {CFG_FRAME_COUNT, CFG_PAGE_SHIFT});

	always_comb begin
		if (frame_count_q == '0) begin
			eff_frames = CW'(1);
		end else if (32'(frame_count_q) > 32'(MAX_FRAMES)) begin
			eff_frames = CW'(MAX_FRAMES);
		end else begin
			eff_frames = CW'(frame_count_q);
		end
	end

	always_comb begin
		if (32'(page_shift_q) > 32'(MAX_PAGE_SHIFT)) begin
			eff_shift = SW'(MAX_PAGE_SHIFT);
		end else begin
			eff_shift = SW'(page_shift_q);
		end
	end

	ptlf_seq #(
		.MAX_FRAMES     (MAX_FRAMES),
		.MAX_PAGE_SHIFT (MAX_PAGE_SHIFT)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res        (res),
		.frames     (eff_frames),
		.shift      (eff_shift),
		.mode       (replace_mode_q),
		.fill       (fill),
		.op         (seq_op),
		.pos        (pos),
		.used       (used),
		.wr_page    (wr_page),
		.wr_frame   (wr_frame),
		.rd_idx     (rd_idx),
		.rd_page    (rd_page),
		.rd_frame   (rd_frame),
		.head_frame (head_frame)
	);

	always_comb begin
		tbl_op       = seq_op;
		tbl_op.clear = cfg_clear;
	end

	ptlf_table #(
		.MAX_FRAMES (MAX_FRAMES)
	) u_table (
		.clk        (clk),
		.arst_n     (arst_n),
		.op         (tbl_op),
		.pos        (pos),
		.used       (used),
		.wr_page    (wr_page),
		.wr_frame   (wr_frame),
		.rd_idx     (rd_idx),
		.rd_page    (rd_page),
		.rd_frame   (rd_frame),
		.head_frame (head_frame),
		.fill       (fill)
	);

	// hold the result until its transfer
	assign res_ready = !rsp_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			rsp_q <= res;
		end
	end

	assign rsp.valid   = rsp_valid_q;
	assign rsp.payload = rsp_q;

endmodule

@@ design/ptlf_checker.sv @@
// ----------------------------------------------------------------------------
// Page table port checker
// Port-level assertions, bound to the page table top level.
// ----------------------------------------------------------------------------
`include "page_table_lru_fifo_defines.svh"

module ptlf_checker import ptlf_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      req_valid,
	input logic      req_ready,
	input logic      rsp_valid,
	input logic      rsp_ready,
	input ptlf_rsp_t rsp_payload
);

	`PTLF_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload), "result changed or dropped while stalled")
	`PTLF_ASSERT_NOW(a_fault_no_addr, clk, arst_n, rsp_valid && rsp_payload.page_fault, rsp_payload.physical_address == 20'd0, "fault result carries an address")
	`PTLF_ASSERT_NEXT(a_busy_after_req, clk, arst_n, req_valid && req_ready, !req_ready, "request taken while a translation is in flight")

endmodule

bind page_table_lru_fifo ptlf_checker u_ptlf_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (req.valid),
	.req_ready   (req.ready),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.rsp_payload (rsp.payload)
);
